// ===== src/lucb_pkg.sv =====
`timescale 1ns / 1ps
package lucb_pkg;

	localparam int NUM_ARMS_DEF = 4;
	localparam int NUM_LEARNERS_DEF = 8;

	// widest store addresses over the parameter range
	localparam int INV_AW_MAX = 12;
	localparam int B_AW_MAX = 10;

	localparam logic [14:0] ONE_Q14 = 15'd16384;
	localparam logic [15:0] GAIN_RESET = 16'd4096;
	localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
	localparam logic signed [31:0] SCORE_MIN = 32'sh8000_0000;

	// rank-one divide: |ax_i * ax_j| < 2^63, denominator >= 2^30, quotient < 2^33
	localparam int DIV_NW = 63;
	localparam int DIV_QW = 33;
	localparam int DIV_DW = 36;
	localparam int ROOT_W = 32;

	typedef enum logic {
		OP_UPDATE = 1'b0,
		OP_SCORE  = 1'b1
	} lucb_op_t;

	typedef struct packed {
		logic        operation;
		logic [2:0]  learner;
		logic [1:0]  arm;
		logic [14:0] feature_load;
		logic [14:0] feature_energy;
		logic [14:0] feature_signal;
		logic [14:0] feature_bias;
		logic [14:0] reward;
		logic        final_arm;
	} lucb_in_t;

	typedef struct packed {
		logic signed [31:0] score;
		logic [1:0]         best_so_far;
		logic               round_done;
		logic               switched;
	} lucb_out_t;

	typedef struct packed {
		logic [INV_AW_MAX-1:0] inv_raddr;
		logic                  inv_we;
		logic [INV_AW_MAX-1:0] inv_waddr;
		logic [31:0]           inv_wdata;
		logic [B_AW_MAX-1:0]   b_raddr;
		logic                  b_we;
		logic [B_AW_MAX-1:0]   b_waddr;
		logic [31:0]           b_wdata;
	} lucb_mem_req_t;

	function automatic logic [14:0] clamp_q14(input logic [14:0] v);
		return (v > ONE_Q14) ? ONE_Q14 : v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sh0000_0000_7FFF_FFFF) begin
			return 32'sh7FFF_FFFF;
		end
		if (v < -64'sh0000_0000_8000_0000) begin
			return SCORE_MIN;
		end
		return v[31:0];
	endfunction

endpackage

// ===== src/lucb_store.sv =====
`timescale 1ns / 1ps
module lucb_store #(
	parameter int NUM_LEARNERS = lucb_pkg::NUM_LEARNERS_DEF,
	parameter int NUM_ARMS = lucb_pkg::NUM_ARMS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lucb_pkg::lucb_mem_req_t req,
	output logic [31:0]            inv_rdata,
	output logic [31:0]            b_rdata,
	output logic                   clearing
);
	import lucb_pkg::*;

	localparam int ENT = NUM_LEARNERS * NUM_ARMS;
	localparam int EW = (ENT > 1) ? $clog2(ENT) : 1;
	localparam int INV_AW = EW + 4;
	localparam int B_AW = EW + 2;
	localparam int INV_DEPTH = ENT * 16;
	localparam int B_DEPTH = ENT * 4;

	logic [31:0] inv_mem [INV_DEPTH];
	logic [31:0] b_mem [B_DEPTH];

	logic [INV_AW-1:0] clr_cnt_q;
	logic              clearing_q;

	// one entry per cycle: identity into the inverses, zero into b
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			if (clr_cnt_q == INV_AW'(INV_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			inv_mem[clr_cnt_q] <= (clr_cnt_q[3:2] == clr_cnt_q[1:0]) ? ONE_Q30 : '0;
			b_mem[clr_cnt_q[INV_AW-1:2]] <= '0;
		end else begin
			if (req.inv_we) begin
				inv_mem[req.inv_waddr[INV_AW-1:0]] <= req.inv_wdata;
			end
			if (req.b_we) begin
				b_mem[req.b_waddr[B_AW-1:0]] <= req.b_wdata;
			end
		end
		inv_rdata <= inv_mem[req.inv_raddr[INV_AW-1:0]];
		b_rdata   <= b_mem[req.b_raddr[B_AW-1:0]];
	end

	assign clearing = clearing_q;

endmodule

// ===== src/lucb_isqrt.sv =====
`timescale 1ns / 1ps
module lucb_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic [63:0]                 value,
	output logic                        done,
	output logic [lucb_pkg::ROOT_W-1:0] root
);
	import lucb_pkg::*;

	logic        run_q;
	logic        done_q;
	logic [63:0] v_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [63:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && bit_q[0];
			if (go) begin
				run_q <= 1'b1;
			end else if (run_q && bit_q[0]) begin
				run_q <= 1'b0;
			end
		end
	end

	// one root bit per step from two radicand bits, 32 steps
	always_ff @(posedge clk) begin
		if (go) begin
			v_q   <= value;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (run_q) begin
			if (v_q >= trial) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[ROOT_W-1:0];

endmodule

// ===== src/lucb_div.sv =====
`timescale 1ns / 1ps
module lucb_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic [lucb_pkg::DIV_NW-1:0] num,
	input  logic [lucb_pkg::DIV_DW-1:0] den,
	output logic                        done,
	output logic [lucb_pkg::DIV_QW-1:0] quot
);
	import lucb_pkg::*;

	localparam int CW = $clog2(DIV_QW);

	logic              run_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_QW-1:0] quo_q;
	logic [DIV_DW:0]   tmp;
	logic              ge;

	assign tmp = {rem_q, quo_q[DIV_QW-1]};
	assign ge  = tmp >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_QW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring divide, one quotient bit per cycle; top bits start below den
	always_ff @(posedge clk) begin
		if (go) begin
			den_q <= den;
			rem_q <= DIV_DW'(num[DIV_NW-1:DIV_QW]);
			quo_q <= num[DIV_QW-1:0];
		end else if (run_q) begin
			rem_q <= ge ? DIV_DW'(tmp - {1'b0, den_q}) : tmp[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// ===== src/linucb_arm_score_and_update.sv =====
`timescale 1ns / 1ps
// Score beat: 4 b reads, then inverse reads and row sums, the 32-step root, and the
// finishing states ST_EX and ST_OUT; done is raised as busy falls.
// Update beat: no result; after the b and inverse reads, each of the 16 inverse entries goes
// around the 33-step rank-one divider. One item at a time; busy is high while an item runs.
// Reset clears control state, then a pass over NUM_LEARNERS*NUM_ARMS*16 entries (512 by
// default) loads identity inverses and zero b vectors while busy stays high; no stall.
module linucb_arm_score_and_update #(
	parameter int NUM_LEARNERS = lucb_pkg::NUM_LEARNERS_DEF,
	parameter int NUM_ARMS = lucb_pkg::NUM_ARMS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic               start,
	output logic               busy,
	input  lucb_pkg::lucb_in_t  item,
	output logic               done,
	output lucb_pkg::lucb_out_t result
);
	import lucb_pkg::*;

	localparam int ENT = NUM_LEARNERS * NUM_ARMS;
	localparam int EW = (ENT > 1) ? $clog2(ENT) : 1;
	localparam int LW = (NUM_LEARNERS > 1) ? $clog2(NUM_LEARNERS) : 1;

	typedef enum logic [11:0] {
		ST_IDLE = 12'b0000_0000_0001,
		ST_SB   = 12'b0000_0000_0010,
		ST_SM   = 12'b0000_0000_0100,
		ST_SQ   = 12'b0000_0000_1000,
		ST_EX   = 12'b0000_0001_0000,
		ST_OUT  = 12'b0000_0010_0000,
		ST_UB   = 12'b0000_0100_0000,
		ST_UM   = 12'b0000_1000_0000,
		ST_UD   = 12'b0001_0000_0000,
		ST_UN   = 12'b0010_0000_0000,
		ST_UP   = 12'b0100_0000_0000,
		ST_UV   = 12'b1000_0000_0000
	} state_t;

	state_t state_q;

	logic [15:0] gain_q;
	logic        clearing;
	logic        accept;
	logic        item_ok;
	logic [LW-1:0] l_in;
	logic [1:0]  a_sel;
	logic [14:0] feat [4];

	// item registers
	logic          op_q;
	logic [LW-1:0] l_q;
	logic [1:0]    a_q;
	logic          fin_q;
	logic [14:0]   r_q;
	logic [14:0]   x_q [4];
	logic [EW-1:0] ent_q;
	logic [4:0]    iss_q;

	// per learner state
	logic [1:0]  saved_arm_q [NUM_LEARNERS];
	logic [1:0]  cur_arm_q [NUM_LEARNERS];
	logic [14:0] saved_ctx_q [NUM_LEARNERS][4];

	// round state
	logic               rb_active_q;
	logic signed [31:0] rb_score_q;
	logic [1:0]         rb_arm_q;
	logic [14:0]        rb_ctx_q [4];

	// store
	lucb_mem_req_t mreq;
	logic [31:0]   inv_rdata;
	logic [31:0]   b_rdata;

	// read pipeline
	logic       rb_s1;
	logic [1:0] j_s1;
	logic       rm_s1;
	logic [3:0] k_s1;
	logic       v_s2;
	logic [3:0] k_s2;
	logic       v_s3;
	logic [1:0] i_s3;
	logic       v_s4;
	logic signed [47:0] pmx_s2;
	logic signed [63:0] pmb_s2;
	logic signed [32:0] sr_s3;
	logic signed [35:0] th_s3;

	logic signed [31:0] b_q [4];
	logic signed [31:0] ax_q [4];
	logic signed [48:0] s_acc_q;
	logic signed [35:0] th_acc_q;
	logic signed [63:0] q_acc_q;
	logic signed [63:0] ex_acc_q;
	logic signed [49:0] d_acc_q;
	logic [DIV_DW-1:0]  den_q;
	logic signed [63:0] p_q;
	logic signed [31:0] m_q;
	logic               mcap_q;
	logic [ROOT_W-1:0]  root_q;
	logic [35:0]        explore_q;
	logic               done_q;
	lucb_out_t          result_q;

	// combinational
	logic signed [47:0] pmx;
	logic signed [63:0] pmb;
	logic signed [48:0] srow;
	logic signed [35:0] throw;
	logic signed [48:0] qterm;
	logic signed [51:0] exterm;
	logic signed [47:0] dterm;
	logic signed [37:0] dsum;
	logic [29:0]        radd;
	logic signed [33:0] bsum;
	logic signed [63:0] prod;
	logic [63:0]        sq_value;
	logic               sq_go;
	logic               sq_done;
	logic [ROOT_W-1:0]  sq_root;
	logic               dv_done;
	logic [DIV_QW-1:0]  dv_quot;
	logic [DIV_NW-1:0]  p_mag;
	logic signed [34:0] t_signed;
	logic signed [31:0] m_new;
	logic signed [31:0] score_c;
	logic               take;
	logic [1:0]         best_c;

	assign feat[0] = item.feature_load;
	assign feat[1] = item.feature_energy;
	assign feat[2] = item.feature_signal;
	assign feat[3] = item.feature_bias;

	assign busy    = (state_q != ST_IDLE) || clearing;
	assign accept  = start && !busy;
	assign l_in    = LW'(item.learner);
	assign a_sel   = (item.operation == OP_SCORE) ? item.arm : saved_arm_q[l_in];
	assign item_ok = (int'(item.learner) < NUM_LEARNERS) &&
		((item.operation == OP_UPDATE) || (int'(item.arm) < NUM_ARMS));

	lucb_store #(
		.NUM_LEARNERS(NUM_LEARNERS),
		.NUM_ARMS(NUM_ARMS)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.req(mreq),
		.inv_rdata(inv_rdata),
		.b_rdata(b_rdata),
		.clearing(clearing)
	);

	// datapath arithmetic
	always_comb begin
		pmx    = $signed(inv_rdata) * $signed({1'b0, x_q[k_s1[1:0]]});
		pmb    = $signed(inv_rdata) * b_q[k_s1[1:0]];
		srow   = s_acc_q + 49'(pmx_s2);
		throw  = th_acc_q + 36'(pmb_s2 >>> 30);
		qterm  = sr_s3 * $signed({1'b0, x_q[i_s3]});
		exterm = th_s3 * $signed({1'b0, x_q[i_s3]});
		dterm  = $signed({1'b0, x_q[iss_q[1:0]]}) * ax_q[iss_q[1:0]];
		dsum   = 38'(ONE_Q30) + 38'(d_acc_q >>> 14);
		radd   = r_q * x_q[j_s1];
		bsum   = 34'($signed(b_rdata)) + $signed({18'b0, radd[29:14]});
		prod   = ax_q[iss_q[3:2]] * ax_q[iss_q[1:0]];
		p_mag  = p_q[63] ? DIV_NW'(-p_q) : p_q[DIV_NW-1:0];
		t_signed = p_q[63] ? -$signed({2'b0, dv_quot}) : $signed({2'b0, dv_quot});
		m_new  = sat32(64'(m_q) - 64'(t_signed));
		sq_value = q_acc_q[63] ? 64'd0 : (q_acc_q >> 10);
		sq_go  = (state_q == ST_SM) && v_s4;
		score_c = sat32((ex_acc_q >>> 12) + $signed({28'b0, explore_q}));
		take   = !rb_active_q || (score_c > rb_score_q);
		best_c = take ? a_q : rb_arm_q;
	end

	// store requests
	always_comb begin
		mreq = '0;
		mreq.b_raddr = B_AW_MAX'({ent_q, iss_q[1:0]});
		mreq.inv_raddr = INV_AW_MAX'({ent_q, iss_q[3:0]});
		if (rb_s1 && (op_q == OP_UPDATE)) begin
			mreq.b_we    = 1'b1;
			mreq.b_waddr = B_AW_MAX'({ent_q, j_s1});
			mreq.b_wdata = sat32(64'(bsum));
		end
		if ((state_q == ST_UV) && dv_done) begin
			mreq.inv_we    = 1'b1;
			mreq.inv_waddr = INV_AW_MAX'({ent_q, iss_q[3:0]});
			mreq.inv_wdata = m_new;
		end
	end

	lucb_isqrt u_isqrt (
		.clk(clk),
		.arst_n(arst_n),
		.go(sq_go),
		.value(sq_value),
		.done(sq_done),
		.root(sq_root)
	);

	lucb_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.go(mcap_q),
		.num(p_mag),
		.den(den_q),
		.done(dv_done),
		.quot(dv_quot)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iss_q       <= '0;
			gain_q      <= GAIN_RESET;
			done_q      <= 1'b0;
			rb_s1       <= 1'b0;
			rm_s1       <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			mcap_q      <= 1'b0;
			rb_active_q <= 1'b0;
			rb_score_q  <= SCORE_MIN;
			rb_arm_q    <= '0;
			for (int l = 0; l < NUM_LEARNERS; l++) begin
				saved_arm_q[l] <= '0;
				cur_arm_q[l]   <= '0;
				for (int k = 0; k < 4; k++) begin
					saved_ctx_q[l][k] <= '0;
				end
			end
			for (int k = 0; k < 4; k++) begin
				rb_ctx_q[k] <= '0;
			end
		end else begin
			if (cfg_we) begin
				gain_q <= cfg_wdata;
			end
			done_q <= (state_q == ST_OUT);
			rb_s1  <= (state_q == ST_SB) || (state_q == ST_UB);
			rm_s1  <= ((state_q == ST_SM) || (state_q == ST_UM)) && !iss_q[4];
			v_s2   <= rm_s1;
			v_s3   <= v_s2 && (k_s2[1:0] == 2'd3) && (op_q == OP_SCORE);
			v_s4   <= v_s3 && (i_s3 == 2'd3);
			mcap_q <= (state_q == ST_UP);

			case (state_q)
				ST_IDLE: begin
					if (accept && item_ok) begin
						iss_q   <= '0;
						state_q <= (item.operation == OP_SCORE) ? ST_SB : ST_UB;
					end
				end
				ST_SB, ST_UB: begin
					iss_q <= iss_q + 1'b1;
					if (iss_q[1:0] == 2'd3) begin
						iss_q   <= '0;
						state_q <= (state_q == ST_SB) ? ST_SM : ST_UM;
					end
				end
				ST_SM: begin
					if (!iss_q[4]) begin
						iss_q <= iss_q + 1'b1;
					end
					if (v_s4) begin
						state_q <= ST_SQ;
					end
				end
				ST_UM: begin
					if (!iss_q[4]) begin
						iss_q <= iss_q + 1'b1;
					end
					if (v_s2 && (k_s2 == 4'd15)) begin
						iss_q   <= '0;
						state_q <= ST_UD;
					end
				end
				ST_UD: begin
					iss_q <= iss_q + 1'b1;
					if (iss_q[1:0] == 2'd3) begin
						state_q <= ST_UN;
					end
				end
				ST_UN: begin
					iss_q   <= '0;
					state_q <= ST_UP;
				end
				ST_UP: begin
					state_q <= ST_UV;
				end
				ST_UV: begin
					if (dv_done) begin
						if (iss_q[3:0] == 4'd15) begin
							state_q <= ST_IDLE;
						end else begin
							iss_q   <= iss_q + 1'b1;
							state_q <= ST_UP;
						end
					end
				end
				ST_SQ: begin
					if (sq_done) begin
						state_q <= ST_EX;
					end
				end
				ST_EX: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					state_q <= ST_IDLE;
					if (fin_q) begin
						cur_arm_q[l_q]   <= best_c;
						saved_arm_q[l_q] <= best_c;
						for (int k = 0; k < 4; k++) begin
							saved_ctx_q[l_q][k] <= take ? x_q[k] : rb_ctx_q[k];
							rb_ctx_q[k] <= '0;
						end
						rb_active_q <= 1'b0;
						rb_score_q  <= SCORE_MIN;
						rb_arm_q    <= '0;
					end else if (take) begin
						rb_active_q <= 1'b1;
						rb_score_q  <= score_c;
						rb_arm_q    <= a_q;
						for (int k = 0; k < 4; k++) begin
							rb_ctx_q[k] <= x_q[k];
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		j_s1   <= iss_q[1:0];
		k_s1   <= iss_q[3:0];
		k_s2   <= k_s1;
		pmx_s2 <= pmx;
		pmb_s2 <= pmb;
		i_s3   <= k_s2[3:2];
		sr_s3  <= 33'(srow >>> 16);
		th_s3  <= throw;

		if (accept) begin
			op_q  <= item.operation;
			l_q   <= l_in;
			a_q   <= item.arm;
			fin_q <= item.final_arm;
			r_q   <= clamp_q14(item.reward);
			ent_q <= EW'(int'(l_in) * NUM_ARMS + int'(a_sel));
			for (int k = 0; k < 4; k++) begin
				x_q[k] <= (item.operation == OP_SCORE) ? clamp_q14(feat[k]) :
					saved_ctx_q[l_in][k];
			end
			s_acc_q  <= '0;
			th_acc_q <= '0;
			q_acc_q  <= '0;
			ex_acc_q <= '0;
			d_acc_q  <= '0;
		end

		if (rb_s1) begin
			b_q[j_s1] <= $signed(b_rdata);
		end

		// row sums of A^-1 x and A^-1 b
		if (v_s2) begin
			if (k_s2[1:0] == 2'd3) begin
				s_acc_q  <= '0;
				th_acc_q <= '0;
				ax_q[k_s2[3:2]] <= sat32(64'(srow >>> 14));
			end else begin
				s_acc_q  <= srow;
				th_acc_q <= throw;
			end
		end

		if (v_s3) begin
			q_acc_q  <= q_acc_q + 64'(qterm);
			ex_acc_q <= ex_acc_q + 64'(exterm);
		end

		if (state_q == ST_UD) begin
			d_acc_q <= d_acc_q + 50'(dterm);
		end
		if (state_q == ST_UN) begin
			den_q <= (dsum < 38'(ONE_Q30)) ? DIV_DW'(ONE_Q30) : DIV_DW'(dsum);
		end
		if (state_q == ST_UP) begin
			p_q <= prod;
		end
		if (mcap_q) begin
			m_q <= $signed(inv_rdata);
		end

		if (sq_done) begin
			root_q <= sq_root;
		end
		if (state_q == ST_EX) begin
			explore_q <= 36'((48'(gain_q) * 48'(root_q)) >> 12);
		end
		if (state_q == ST_OUT) begin
			result_q.score       <= score_c;
			result_q.best_so_far <= best_c;
			result_q.round_done  <= fin_q;
			result_q.switched    <= fin_q && (best_c != cur_arm_q[l_q]);
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== src/lucb_chk.sv =====
`timescale 1ns / 1ps
module lucb_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input lucb_pkg::lucb_out_t result
);
	import lucb_pkg::*;

	// the result beat lands as the engine goes idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two result beats back to back");

	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result one cycle after accept");

	a_switch_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.switched) |-> result.round_done)
		else $error("switch flagged outside round end");

endmodule

bind linucb_arm_score_and_update lucb_chk u_lucb_chk (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.result(result)
);

// ===== tb/tb_linucb_arm_score_and_update.sv =====
`timescale 1ns / 1ps
module tb_linucb_arm_score_and_update;
	import lucb_pkg::*;

	localparam int N_LRN = 8;
	localparam int N_ARM = 4;
	localparam int UPDATE_DRAIN = 700;
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic start = 1'b0;
	logic busy;
	lucb_in_t item = '0;
	logic done;
	lucb_out_t result;

	linucb_arm_score_and_update #(.NUM_LEARNERS(N_LRN), .NUM_ARMS(N_ARM)) DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.start(start), .busy(busy), .item(item), .done(done), .result(result)
	);

	always #5 clk = ~clk;

	// model state
	logic [15:0] gain_m;
	logic signed [31:0] inv_m [N_LRN][N_ARM][16];
	logic signed [31:0] bsum_m [N_LRN][N_ARM][4];
	longint ctx_saved [N_LRN][4];
	logic [1:0] arm_saved [N_LRN];
	logic [1:0] arm_current [N_LRN];
	logic signed [31:0] best_score;
	logic [1:0] best_arm;
	longint best_ctx [4];
	bit round_open;
	longint xin [4];

	lucb_in_t pend_q [$];
	lucb_out_t score_q [$];
	int fails = 0;
	int n_scores = 0, n_updates = 0, n_rounds = 0, n_switches = 0;
	bit no_idle = 1'b0;
	int stall_cnt = 0;

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint q14_clamp(logic [14:0] v);
		return (v > 15'd16384) ? 64'd16384 : longint'(v);
	endfunction

	function automatic longint unsigned int_root(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic signed [31:0] arm_score(int l, int a);
		longint q, exploit, s, th;
		longint unsigned rt, ex;
		q = 0;
		exploit = 0;
		for (int i = 0; i < 4; i++) begin
			s = 0;
			th = 0;
			for (int j = 0; j < 4; j++) begin
				s += longint'(inv_m[l][a][i*4+j]) * xin[j];
				th += (longint'(inv_m[l][a][i*4+j]) * longint'(bsum_m[l][a][j])) >>> 30;
			end
			q += xin[i] * (s >>> 16);
			exploit += th * xin[i];
		end
		if (q < 0) q = 0;
		rt = int_root(longint'(q) >> 10);
		ex = (longint'(gain_m) * rt) >> 12;
		return 32'(clip32((exploit >>> 12) + longint'(ex)));
	endfunction

	task automatic reward_update(int l, longint r);
		int a;
		longint ax [4];
		longint s, d, t;
		a = arm_saved[l];
		for (int i = 0; i < 4; i++)
			bsum_m[l][a][i] = 32'(clip32(longint'(bsum_m[l][a][i]) + ((r * ctx_saved[l][i]) >> 14)));
		for (int i = 0; i < 4; i++) begin
			s = 0;
			for (int j = 0; j < 4; j++)
				s += longint'(inv_m[l][a][i*4+j]) * ctx_saved[l][j];
			ax[i] = clip32(s >>> 14);
		end
		d = 0;
		for (int i = 0; i < 4; i++)
			d += ctx_saved[l][i] * ax[i];
		d = (64'sd1 << 30) + (d >>> 14);
		// rounding drift can push the denominator below one
		if (d < (64'sd1 << 30)) d = 64'sd1 << 30;
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++) begin
				t = (ax[i] * ax[j]) / d;
				inv_m[l][a][i*4+j] = 32'(clip32(longint'(inv_m[l][a][i*4+j]) - t));
			end
	endtask

	task automatic model_beat(lucb_in_t it);
		int l, a;
		logic signed [31:0] s;
		lucb_out_t o;
		l = it.learner;
		a = it.arm;
		xin[0] = q14_clamp(it.feature_load);
		xin[1] = q14_clamp(it.feature_energy);
		xin[2] = q14_clamp(it.feature_signal);
		xin[3] = q14_clamp(it.feature_bias);
		if (lucb_op_t'(it.operation) == OP_UPDATE) begin
			reward_update(l, q14_clamp(it.reward));
			n_updates++;
			return;
		end
		s = arm_score(l, a);
		if (!round_open || s > best_score) begin
			best_score = s;
			best_arm = 2'(a);
			for (int k = 0; k < 4; k++) best_ctx[k] = xin[k];
			round_open = 1'b1;
		end
		o.score = s;
		o.best_so_far = best_arm;
		o.round_done = it.final_arm;
		o.switched = 1'b0;
		if (it.final_arm) begin
			o.switched = (best_arm != arm_current[l]);
			arm_current[l] = best_arm;
			arm_saved[l] = best_arm;
			for (int k = 0; k < 4; k++) ctx_saved[l][k] = best_ctx[k];
			best_score = SCORE_MIN;
			best_arm = '0;
			for (int k = 0; k < 4; k++) best_ctx[k] = 0;
			round_open = 1'b0;
			n_rounds++;
			if (o.switched) n_switches++;
		end
		score_q.insert(score_q.size(), o);
		n_scores++;
	endtask

	initial begin
		gain_m = GAIN_RESET;
		for (int l = 0; l < N_LRN; l++) begin
			for (int a = 0; a < N_ARM; a++)
				for (int k = 0; k < 16; k++) begin
					inv_m[l][a][k] = (k % 5 == 0) ? ONE_Q30 : 32'sd0;
					if (k < 4) bsum_m[l][a][k] = 0;
				end
			for (int k = 0; k < 4; k++) ctx_saved[l][k] = 0;
			arm_saved[l] = '0;
			arm_current[l] = '0;
		end
		best_score = SCORE_MIN;
		best_arm = '0;
		for (int k = 0; k < 4; k++) best_ctx[k] = 0;
		round_open = 1'b0;
	end

	// driver
	always @(posedge clk) begin
		bit acc;
		bit nstart;
		lucb_in_t nitem;
		acc = start && !busy;
		nstart = start;
		nitem = item;
		if (arst_n) begin
			if (acc) model_beat(item);
			if (acc || !start) begin
				if (pend_q.size() > 0 && (no_idle || $urandom_range(99) >= 31)) begin
					nitem = pend_q.pop_front();
					nstart = 1'b1;
				end else begin
					nstart = 1'b0;
				end
			end
		end
		start <= nstart;
		item <= nitem;
	end

	// monitor
	always @(posedge clk) begin
		lucb_out_t e;
		if (arst_n && done) begin
			if (score_q.size() == 0) begin
				$error("result beat with nothing expected: score %0d", result.score);
				fails++;
			end else begin
				e = score_q.pop_front();
				if (result.score !== e.score) begin
					$error("score: expected %0d, got %0d", e.score, result.score);
					fails++;
				end
				if (result.best_so_far !== e.best_so_far) begin
					$error("best_so_far: expected %0d, got %0d", e.best_so_far, result.best_so_far);
					fails++;
				end
				if (result.round_done !== e.round_done) begin
					$error("round_done: expected %0d, got %0d", e.round_done, result.round_done);
					fails++;
				end
				if (result.switched !== e.switched) begin
					$error("switched: expected %0d, got %0d", e.switched, result.switched);
					fails++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	function automatic logic [14:0] rand_feat();
		int p;
		p = $urandom_range(99);
		if (p < 70) return 15'($urandom_range(16384));
		if (p < 85) return 15'($urandom);
		return (p < 92) ? 15'd0 : 15'd16384;
	endfunction

	function automatic lucb_in_t mk_beat(logic op, int l, int a, logic fin, logic [14:0] r);
		lucb_in_t it;
		it.operation = op;
		it.learner = 3'(l);
		it.arm = 2'(a);
		it.feature_load = rand_feat();
		it.feature_energy = rand_feat();
		it.feature_signal = rand_feat();
		it.feature_bias = ($urandom_range(3) == 0) ? rand_feat() : ONE_Q14;
		it.reward = r;
		it.final_arm = fin;
		return it;
	endfunction

	function automatic lucb_in_t ctx_beat(int l, int a, logic fin, logic [14:0] f);
		lucb_in_t it;
		it = mk_beat(OP_SCORE, l, a, fin, 15'($urandom));
		it.feature_load = f;
		it.feature_energy = f;
		it.feature_signal = f;
		it.feature_bias = f;
		return it;
	endfunction

	task automatic queue_beat(lucb_in_t it);
		pend_q.insert(pend_q.size(), it);
	endtask

	// one well-formed round, usually followed by its update
	task automatic push_round();
		int l, mask, last;
		l = $urandom_range(N_LRN - 1);
		mask = $urandom_range(15, 1);
		last = 0;
		for (int a = 0; a < N_ARM; a++) if (mask[a]) last = a;
		for (int a = 0; a < N_ARM; a++)
			if (mask[a]) queue_beat(mk_beat(OP_SCORE, l, a, a == last, 15'($urandom)));
		if ($urandom_range(99) < 55)
			queue_beat(mk_beat(OP_UPDATE, l, $urandom_range(3), 1'($urandom_range(1)),
				($urandom_range(3) == 0) ? 15'($urandom) : 15'($urandom_range(16384))));
	endtask

	task automatic run_phase(int nbeats);
		int goal;
		goal = n_scores + n_updates + pend_q.size() + nbeats;
		while (n_scores + n_updates + pend_q.size() < goal) begin
			if ($urandom_range(99) < 12)
				queue_beat(mk_beat(1'($urandom_range(1)), $urandom_range(N_LRN - 1),
					$urandom_range(3), 1'($urandom_range(1)), 15'($urandom)));
			else
				push_round();
		end
		while (pend_q.size() > 0 || start || score_q.size() > 0) @(posedge clk);
		// an update may still be running after the last result
		repeat (UPDATE_DRAIN) @(posedge clk);
	endtask

	task automatic set_gain(logic [15:0] g);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= g;
		gain_m = g;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// update before any round: arm 0, zero context
		queue_beat(mk_beat(OP_UPDATE, 0, 2, 1'b0, 15'd16384));
		queue_beat(ctx_beat(0, 0, 1'b0, 15'd0));
		queue_beat(ctx_beat(0, 1, 1'b0, 15'h7FFF));
		// same context as arm 1: the tie keeps arm 1
		queue_beat(ctx_beat(0, 2, 1'b0, 15'd16384));
		queue_beat(ctx_beat(0, 3, 1'b1, 15'd1));
		queue_beat(mk_beat(OP_UPDATE, 0, 0, 1'b1, 15'h7FFF));
		queue_beat(ctx_beat(0, 1, 1'b1, 15'd16384));
		queue_beat(ctx_beat(7, 3, 1'b1, 15'd16384));
		queue_beat(mk_beat(OP_UPDATE, 7, 0, 1'b0, 15'd0));
		for (int k = 0; k < 4; k++)
			queue_beat(mk_beat(OP_UPDATE, 7, 3, 1'b0, 15'd16384));
		queue_beat(ctx_beat(7, 3, 1'b0, 15'd16384));
		queue_beat(ctx_beat(7, 3, 1'b1, 15'd8192));
		queue_beat(ctx_beat(5, 0, 1'b0, 15'h5555));
		queue_beat(ctx_beat(5, 2, 1'b1, 15'h2AAA));
		queue_beat(mk_beat(OP_UPDATE, 5, 1, 1'b1, 15'h2AAA));
		queue_beat(ctx_beat(5, 2, 1'b1, 15'h2AAA));
		run_phase(0);

		run_phase(160);
		set_gain(16'd0);
		no_idle = 1'b1;
		run_phase(150);
		no_idle = 1'b0;
		set_gain(16'hFFFF);
		run_phase(160);
		set_gain(16'd1);
		run_phase(140);
		set_gain(16'($urandom));
		run_phase(140);
		set_gain(GAIN_RESET);
		run_phase(130);

		$display("covered %0d score beats in %0d rounds (%0d switches), %0d updates",
			n_scores, n_rounds, n_switches, n_updates);
		$display("gain settings 4096, 0, 65535, 1, random, 4096; %0d mismatches", fails);
		if (fails == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
